// ===== src/cvma_pkg.sv =====
// ----------------------------------------------------------------------------
// cvma_pkg
// Shared constants, types and register codes of the cell voltage moving
// average unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cvma_pkg;

  localparam int WINDOW_LEN = 8;
  localparam int LANES      = 4;

  localparam int RAW_W      = 14;
  localparam int GAIN_W     = 9;
  localparam int GAIN_BASE  = 365;
  localparam int OFFS_W     = 8;
  localparam int OFFS_UV_W  = 18;
  localparam int MV_TO_UV   = 1000;
  localparam int SAMPLE_W   = 24;
  localparam int AVG_W      = 24;
  localparam int TOTAL_W    = 26;

  localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_LEN + 1);
  localparam int SLOT_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
  localparam int STEP_W     = $clog2(SUM_W + 1);

  localparam int IN_W       = LANES * RAW_W;
  localparam int OUT_W      = 128;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_TRIM_A = 2'd0,
    REG_GAIN_TRIM_B = 2'd1,
    REG_OFFSET_MV   = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              capture;
    logic              mul;
    logic              upd;
    logic              load;
    logic              step;
    logic              emit;
    logic              full;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  count;
  } lane_ctl_t;

endpackage

`default_nettype wire

// ===== src/cvma_lane.sv =====
// ----------------------------------------------------------------------------
// cvma_lane
// One cell lane: scaling to microvolts, sample window, running sum and a
// bit-serial restoring divider for the window average.
// ----------------------------------------------------------------------------
`default_nettype none

module cvma_lane (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire cvma_pkg::lane_ctl_t                   ctl,
  input  wire logic [cvma_pkg::RAW_W-1:0]            raw,
  input  wire logic [cvma_pkg::GAIN_W-1:0]           gain,
  input  wire logic signed [cvma_pkg::OFFS_UV_W-1:0] offset_uv,
  output logic signed [cvma_pkg::SUM_W-1:0]          avg
);

  localparam int SW = cvma_pkg::SUM_W;
  localparam int CW = cvma_pkg::CNT_W;
  localparam int PW = cvma_pkg::RAW_W + cvma_pkg::GAIN_W;

  logic signed [cvma_pkg::SAMPLE_W-1:0] mem [cvma_pkg::WINDOW_LEN];

  logic [cvma_pkg::RAW_W-1:0]           raw_r;
  logic signed [cvma_pkg::SAMPLE_W-1:0] old_r;
  logic signed [cvma_pkg::SAMPLE_W-1:0] uv_r, uv_nxt;
  logic signed [SW-1:0]                 sum_r, sum_nxt;
  logic [SW-1:0]                        div_r, div_nxt;
  logic [CW-1:0]                        rem_r, rem_nxt;
  logic                                 neg_r;

  logic [PW-1:0]                        prod;
  logic signed [cvma_pkg::SAMPLE_W-1:0] old_eff;
  logic [CW:0]                          rem_sh;
  logic                                 ge;

  assign prod   = PW'(raw_r) * PW'(gain);
  assign uv_nxt = cvma_pkg::SAMPLE_W'(prod)
                + {{(cvma_pkg::SAMPLE_W - cvma_pkg::OFFS_UV_W){offset_uv[cvma_pkg::OFFS_UV_W-1]}},
                   offset_uv};

  // Slots not yet written since reset read as zero.
  assign old_eff = ctl.full ? old_r : '0;
  assign sum_nxt = sum_r
                 + {{(SW - cvma_pkg::SAMPLE_W){uv_r[cvma_pkg::SAMPLE_W-1]}}, uv_r}
                 - {{(SW - cvma_pkg::SAMPLE_W){old_eff[cvma_pkg::SAMPLE_W-1]}}, old_eff};

  // One quotient bit per cycle, quotient shifts in behind the dividend.
  assign rem_sh  = {rem_r, div_r[SW-1]};
  assign ge      = (rem_sh >= {1'b0, ctl.count});
  assign rem_nxt = ge ? CW'(rem_sh - {1'b0, ctl.count}) : CW'(rem_sh);
  assign div_nxt = {div_r[SW-2:0], ge};

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      mem[ctl.slot] <= uv_r;
    end
    if (ctl.capture) begin
      old_r <= mem[ctl.slot];
      raw_r <= raw;
    end
    if (ctl.mul) begin
      uv_r <= uv_nxt;
    end
    if (ctl.load) begin
      neg_r <= sum_r[SW-1];
      div_r <= sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
      rem_r <= '0;
    end else if (ctl.step) begin
      div_r <= div_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctl.upd) begin
      sum_r <= sum_nxt;
    end
  end

  assign avg = neg_r ? -$signed(div_r) : $signed(div_r);

endmodule

`default_nettype wire

// ===== src/cvma_ctrl.sv =====
// ----------------------------------------------------------------------------
// cvma_ctrl
// Sequencer of the lanes: window slot and fill tracking, divisor count and
// divider step counter.
// ----------------------------------------------------------------------------
`default_nettype none

module cvma_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_fire,
  input  wire logic           out_free,
  output logic                in_ready,
  output cvma_pkg::lane_ctl_t ctl
);

  localparam logic [cvma_pkg::SLOT_W-1:0] SLOT_LAST =
    cvma_pkg::SLOT_W'(cvma_pkg::WINDOW_LEN - 1);

  cvma_pkg::state_t state_r, state_nxt;

  logic [cvma_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic                        full_r, full_nxt;
  logic [cvma_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [cvma_pkg::STEP_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cvma_pkg::ST_IDLE: if (in_fire) state_nxt = cvma_pkg::ST_MUL;
      cvma_pkg::ST_MUL:  state_nxt = cvma_pkg::ST_UPD;
      cvma_pkg::ST_UPD:  state_nxt = cvma_pkg::ST_LOAD;
      cvma_pkg::ST_LOAD: state_nxt = cvma_pkg::ST_DIV;
      cvma_pkg::ST_DIV:  if (step_r == cvma_pkg::STEP_W'(1)) state_nxt = cvma_pkg::ST_OUT;
      cvma_pkg::ST_OUT:  if (out_free) state_nxt = cvma_pkg::ST_IDLE;
      default:           state_nxt = cvma_pkg::ST_IDLE;
    endcase
  end

  // Ready depends on state only, so the accept strobe never loops back into it.
  assign in_ready = (state_r == cvma_pkg::ST_IDLE);

  always_comb begin
    ctl         = '0;
    ctl.full    = full_r;
    ctl.slot    = slot_r;
    ctl.count   = count_r;
    unique case (state_r)
      cvma_pkg::ST_IDLE: ctl.capture = in_fire;
      cvma_pkg::ST_MUL:  ctl.mul  = 1'b1;
      cvma_pkg::ST_UPD:  ctl.upd  = 1'b1;
      cvma_pkg::ST_LOAD: ctl.load = 1'b1;
      cvma_pkg::ST_DIV:  ctl.step = 1'b1;
      cvma_pkg::ST_OUT:  ctl.emit = out_free;
      default: ;
    endcase
  end

  always_comb begin
    slot_nxt  = slot_r;
    full_nxt  = full_r;
    count_nxt = count_r;
    step_nxt  = step_r;
    if (in_fire && state_r == cvma_pkg::ST_IDLE) begin
      count_nxt = full_r ? cvma_pkg::CNT_W'(cvma_pkg::WINDOW_LEN)
                         : cvma_pkg::CNT_W'(slot_r) + cvma_pkg::CNT_W'(1);
    end
    if (state_r == cvma_pkg::ST_UPD) begin
      if (slot_r == SLOT_LAST) begin
        slot_nxt = '0;
        full_nxt = 1'b1;
      end else begin
        slot_nxt = slot_r + cvma_pkg::SLOT_W'(1);
      end
    end
    if (state_r == cvma_pkg::ST_LOAD) begin
      step_nxt = cvma_pkg::STEP_W'(cvma_pkg::SUM_W);
    end else if (state_r == cvma_pkg::ST_DIV) begin
      step_nxt = step_r - cvma_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cvma_pkg::ST_IDLE;
      slot_r  <= '0;
      full_r  <= 1'b0;
      count_r <= cvma_pkg::CNT_W'(1);
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      full_r  <= full_nxt;
      count_r <= count_nxt;
      step_r  <= step_nxt;
    end
  end

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SLOT_LAST)
    else $error("window slot out of range");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cvma_pkg::ST_DIV |-> count_r != '0)
    else $error("zero divisor during division");

  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |=> full_r)
    else $error("window full flag dropped");

  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cvma_pkg::ST_UPD && slot_r == SLOT_LAST) |=> (full_r && slot_r == '0))
    else $error("window did not wrap");

endmodule

`default_nettype wire

// ===== src/cell_voltage_moving_average_unit.sv =====
// ----------------------------------------------------------------------------
// cell_voltage_moving_average_unit
// Four-lane boxcar moving average of battery cell voltages in microvolts.
// ----------------------------------------------------------------------------
// Each input transaction carries four raw 14-bit cell codes; each is scaled to
// microvolts (raw * (365 + trim code) + offset_mv * 1000), stored in an
// 8-entry window per cell, and one result transaction returns the four
// truncated window averages and their sum. After acceptance each item is
// captured, scaled, written into the window and loaded into the dividers;
// then each lane's bit-serial divider produces one quotient bit per cycle
// over the 28-bit running sum. One item is in flight at a time; a new item
// is taken while the previous result still waits in the output register.
// Averages start from the first sample after reset (the divisor is the
// number of samples seen, up to the window length). Configuration writes
// are always accepted and apply to every item scaled after the write.
// ----------------------------------------------------------------------------
`default_nettype none

module cell_voltage_moving_average_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // raw_cell_one, raw_cell_two, raw_cell_three, raw_cell_four (14 bits each)
  input  wire logic [cvma_pkg::IN_W-1:0]       in_tdata,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // avg_cell_one_uv .. avg_cell_four_uv (24 bits each), module_sum_uv (26),
  // zero fill
  output logic [cvma_pkg::OUT_W-1:0]           out_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [cvma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cvma_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SW = cvma_pkg::SUM_W;
  localparam int TW = SW + 2;

  logic [cvma_pkg::CFG_DATA_W-1:0] trim_a_r, trim_b_r, offs_r;

  logic [cvma_pkg::GAIN_W-1:0]           gain;
  logic signed [cvma_pkg::OFFS_UV_W-1:0] offs_ext;
  logic signed [cvma_pkg::OFFS_UV_W-1:0] offset_uv;

  cvma_pkg::lane_ctl_t ctl;
  logic                in_fire;
  logic                out_free;

  logic signed [SW-1:0] avg [cvma_pkg::LANES];
  logic signed [TW-1:0] total;

  logic [cvma_pkg::OUT_W-1:0] out_data_r;
  logic                       out_valid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trim_a_r <= '0;
      trim_b_r <= '0;
      offs_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cvma_pkg::REG_GAIN_TRIM_A: trim_a_r <= cfg_data;
        cvma_pkg::REG_GAIN_TRIM_B: trim_b_r <= cfg_data;
        cvma_pkg::REG_OFFSET_MV:   offs_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign gain      = cvma_pkg::GAIN_W'(cvma_pkg::GAIN_BASE)
                   + cvma_pkg::GAIN_W'({trim_a_r[3:2], trim_b_r[7:5]});
  assign offs_ext  = {{(cvma_pkg::OFFS_UV_W - cvma_pkg::OFFS_W){offs_r[cvma_pkg::OFFS_W-1]}},
                      offs_r};
  assign offset_uv = cvma_pkg::OFFS_UV_W'(offs_ext * cvma_pkg::OFFS_UV_W'(cvma_pkg::MV_TO_UV));

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  cvma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .in_ready (in_tready),
    .ctl      (ctl)
  );

  for (genvar g = 0; g < cvma_pkg::LANES; g++) begin : g_lane
    cvma_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .raw       (in_tdata[g*cvma_pkg::RAW_W +: cvma_pkg::RAW_W]),
      .gain      (gain),
      .offset_uv (offset_uv),
      .avg       (avg[g])
    );
  end

  assign total = TW'(avg[0]) + TW'(avg[1]) + TW'(avg[2]) + TW'(avg[3]);

  // Hold the result until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_data_r <= {
        (cvma_pkg::OUT_W - 4*cvma_pkg::AVG_W - cvma_pkg::TOTAL_W)'(0),
        total[cvma_pkg::TOTAL_W-1:0],
        avg[3][cvma_pkg::AVG_W-1:0],
        avg[2][cvma_pkg::AVG_W-1:0],
        avg[1][cvma_pkg::AVG_W-1:0],
        avg[0][cvma_pkg::AVG_W-1:0]
      };
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("second item taken while one is in flight");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> out_free)
    else $error("result overwrote a pending transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("pending result changed or dropped");

endmodule

`default_nettype wire
